// ===== hw/rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the linear contrast stretch block.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int PIX_W      = 8;
	localparam int NUM_W      = 2 * PIX_W;
	localparam int DIV_STEPS  = PIX_W;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);
	localparam int FIFO_DEPTH = 2;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;
	localparam logic [PIX_W-1:0] PIX_MIN = '0;

	typedef enum logic {
		ACT_MEASURE = 1'b0,
		ACT_STRETCH = 1'b1
	} action_t;

	// How the back end finishes a stretch request
	typedef enum logic [1:0] {
		CLS_FLAT = 2'd0,
		CLS_LOW  = 2'd1,
		CLS_HIGH = 2'd2,
		CLS_DIV  = 2'd3
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic [NUM_W-1:0] num;    // (p - lo) * 255
		logic [PIX_W-1:0] den;    // hi - lo
		logic [PIX_W-1:0] fixed;  // result when no division is needed
	} q_entry_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_DIV  = 1'b1
	} bk_state_t;

endpackage

// ===== hw/rtl/lcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_front
// Accepts requests, tracks running min/max, classifies stretch requests and
// pushes them into the work queue.
// ----------------------------------------------------------------------------
module lcs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [lcs_pkg::PIX_W-1:0]     pixel,
	input  logic                          first,
	input  logic                          q_full,
	output logic                          q_push,
	output lcs_pkg::q_entry_t             q_data
);

	logic                      accept;
	logic [lcs_pkg::PIX_W-1:0] lo_q;
	logic [lcs_pkg::PIX_W-1:0] hi_q;
	logic [lcs_pkg::PIX_W-1:0] diff;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (action == lcs_pkg::ACT_STRETCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= lcs_pkg::PIX_MAX;
			hi_q <= lcs_pkg::PIX_MIN;
		end else if (accept && action == lcs_pkg::ACT_MEASURE) begin
			if (first) begin
				lo_q <= pixel;
				hi_q <= pixel;
			end else begin
				if (pixel < lo_q) lo_q <= pixel;
				if (pixel > hi_q) hi_q <= pixel;
			end
		end
	end

	assign diff = pixel - lo_q;

	always_comb begin
		q_data.num   = {diff, {lcs_pkg::PIX_W{1'b0}}} - {{lcs_pkg::PIX_W{1'b0}}, diff};
		q_data.den   = hi_q - lo_q;
		q_data.cls   = lcs_pkg::CLS_DIV;
		q_data.fixed = lo_q;
		if (hi_q <= lo_q) begin
			q_data.cls   = lcs_pkg::CLS_FLAT;
			q_data.fixed = lo_q;
		end else if (pixel < lo_q) begin
			q_data.cls   = lcs_pkg::CLS_LOW;
			q_data.fixed = lcs_pkg::PIX_MIN;
		end else if (pixel > hi_q) begin
			q_data.cls   = lcs_pkg::CLS_HIGH;
			q_data.fixed = lcs_pkg::PIX_MAX;
		end
	end

endmodule

// ===== hw/rtl/lcs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_fifo
// Short work queue between the front and back ends.
// ----------------------------------------------------------------------------
module lcs_fifo #(
	parameter int DEPTH = lcs_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcs_pkg::q_entry_t wdata,
	input  logic              pop,
	output lcs_pkg::q_entry_t rdata,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	lcs_pkg::q_entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/lcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_back
// Pops classified requests, runs a restoring divider one quotient bit per
// cycle and holds the result in the output register.
// ----------------------------------------------------------------------------
module lcs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  lcs_pkg::q_entry_t         q_data,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lcs_pkg::PIX_W-1:0] stretched
);

	lcs_pkg::bk_state_t        state_q;
	lcs_pkg::bk_state_t        state_nxt;
	logic [lcs_pkg::CNT_W-1:0] cnt_q;
	logic [lcs_pkg::NUM_W-1:0] rem_q;
	logic [lcs_pkg::NUM_W-1:0] dsh_q;
	logic [lcs_pkg::PIX_W-1:0] quo_q;
	logic                      out_valid_q;
	logic [lcs_pkg::PIX_W-1:0] out_data_q;
	logic                      out_free;
	logic                      div_load;
	logic                      out_load;
	logic [lcs_pkg::PIX_W-1:0] out_value;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign stretched = out_data_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lcs_pkg::BK_IDLE: begin
				if (!q_empty && q_data.cls == lcs_pkg::CLS_DIV) state_nxt = lcs_pkg::BK_DIV;
			end
			lcs_pkg::BK_DIV: begin
				if (cnt_q == '0 && out_free) state_nxt = lcs_pkg::BK_IDLE;
			end
			default: state_nxt = lcs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		div_load  = 1'b0;
		out_load  = 1'b0;
		out_value = q_data.fixed;
		unique case (state_q)
			lcs_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (q_data.cls == lcs_pkg::CLS_DIV) begin
						q_pop    = 1'b1;
						div_load = 1'b1;
					end else if (out_free) begin
						q_pop    = 1'b1;
						out_load = 1'b1;
					end
				end
			end
			lcs_pkg::BK_DIV: begin
				out_value = quo_q;
				out_load  = (cnt_q == '0) && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcs_pkg::BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (div_load)          cnt_q <= lcs_pkg::CNT_W'(lcs_pkg::DIV_STEPS);
			else if (cnt_q != '0)  cnt_q <= cnt_q - 1'b1;
			if (out_load)          out_valid_q <= 1'b1;
			else if (!out_stall)   out_valid_q <= 1'b0;
		end
	end

	// quotient fits in PIX_W bits since p - lo <= hi - lo
	always_ff @(posedge clk) begin
		if (div_load) begin
			rem_q <= q_data.num;
			dsh_q <= {1'b0, q_data.den, {(lcs_pkg::PIX_W-1){1'b0}}};
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[lcs_pkg::PIX_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[lcs_pkg::PIX_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (out_load) out_data_q <= out_value;
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == lcs_pkg::BK_IDLE)
		else $error("pop while divider busy");

	a_cnt_div: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> state_q == lcs_pkg::BK_DIV)
		else $error("divider stepping outside DIV");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || !out_stall)
		else $error("result overwrites a stalled result");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

// ===== hw/rtl/linear_contrast_stretch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_contrast_stretch
// Two-pass linear contrast stretch of 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage: stream the image once with action = measure (first = 1 on the first
// pixel restarts min/max), then again with action = stretch. Each request on
// the in channel (in_valid/in_stall) carries action, pixel, first. Measure
// requests produce nothing; each stretch request produces one stretched
// pixel on the out channel (out_valid/out_stall), in request order.
// Measure requests are taken one per cycle while the queue has room.
// Stretch requests pass through a FIFO_DEPTH-entry queue to a serial
// divider that retires one quotient bit per cycle: a request needing a
// divide occupies the back end through pop, 8 steps and write-out, and
// the next request is popped only after it; clipped or flat-range
// requests are popped and written to the output register together.
// When the receiver stalls, the result holds in the output register, the
// back end waits at its next write-out and the queue fills; then in_stall rises.
// Reset sets min to 255 and max to 0 and empties the queue and output.
// ----------------------------------------------------------------------------
module linear_contrast_stretch #(
	parameter int FIFO_DEPTH = lcs_pkg::FIFO_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [lcs_pkg::PIX_W-1:0] pixel,
	input  logic                      first,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lcs_pkg::PIX_W-1:0] stretched
);

	lcs_pkg::q_entry_t push_data;
	lcs_pkg::q_entry_t pop_data;
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;

	lcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.pixel    (pixel),
		.first    (first),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	lcs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_data),
		.pop    (q_pop),
		.rdata  (pop_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	lcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stretched (stretched)
	);

endmodule
